// ----- src/shp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_pkg
// Types and constants shared by the stepper homing positioner files.
// ----------------------------------------------------------------------------
package shp_pkg;

  localparam int POS_W   = 24;
  localparam int GOAL_W  = 24;
  localparam int OUT_W   = 24;
  localparam int CFG_W   = 8;
  localparam int STEPS_W = 32;
  localparam int LIM_W   = POS_W + CFG_W + 1;
  localparam int CMP_W   = (POS_W > GOAL_W) ? POS_W : GOAL_W;
  localparam int IDX_W   = 1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = CFG_W'(10);
  localparam logic [CFG_W-1:0] RECAL_RESET    = CFG_W'(10);

  localparam logic [IDX_W-1:0] REG_DEBOUNCE_TICKS = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_RECAL_FACTOR   = IDX_W'(1);

  localparam logic [1:0] SW_OPEN    = 2'd0;
  localparam logic [1:0] SW_PRESSED = 2'd1;

  typedef enum logic [2:0] {
    PH_FIND      = 3'd0,
    PH_LEAVE     = 3'd1,
    PH_MEASURE   = 3'd2,
    PH_LEAVE_TOP = 3'd3,
    PH_RUN       = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_ERROR   = 2'd0,
    ST_CAL     = 2'd1,
    ST_RUNNING = 2'd2,
    ST_READY   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        low_switch;
    logic [1:0]        high_switch;
    logic [GOAL_W-1:0] goal_position;
  } tick_t;

  typedef struct packed {
    logic             step_level;
    logic             direction_level;
    logic [1:0]       motor_status;
    logic [OUT_W-1:0] current_position;
    logic [OUT_W-1:0] travel_span;
  } res_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] recal_factor;
  } cfg_t;

endpackage

// ----- src/shp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_if
// Handshake channels of the stepper homing positioner: tick, result, config.
// ----------------------------------------------------------------------------
interface shp_tick_if import shp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        low_switch;
  logic [1:0]        high_switch;
  logic [GOAL_W-1:0] goal_position;

  modport source(output valid, low_switch, high_switch, goal_position, input ready);
  modport sink(input valid, low_switch, high_switch, goal_position, output ready);
endinterface

interface shp_result_if import shp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             step_level;
  logic             direction_level;
  logic [1:0]       motor_status;
  logic [OUT_W-1:0] current_position;
  logic [OUT_W-1:0] travel_span;

  modport source(output valid, step_level, direction_level, motor_status,
                 current_position, travel_span, input ready);
  modport sink(input valid, step_level, direction_level, motor_status,
               current_position, travel_span, output ready);
endinterface

interface shp_cfg_if import shp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- src/stepper_homing_positioner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_homing_positioner
// Stepper homing and positioning controller driven by limit-switch ticks.
// ----------------------------------------------------------------------------
// One tick is accepted every clock cycle as long as results are taken; each
// tick gives exactly one result, passing first through the input register,
// then through the state machine into the result register. The
// state update is a combinational compare, increment and 24x8 multiply, so
// ticks can follow back to back. Configuration writes are taken at any time
// and apply to later ticks.
module stepper_homing_positioner import shp_pkg::*; (
  input  logic clk,
  input  logic rst,
  shp_tick_if.sink     tick,
  shp_result_if.source result,
  shp_cfg_if.sink      cfg
);

  logic  in_valid;
  tick_t in_data;
  logic  out_valid;
  res_t  out_data;
  logic  advance;
  cfg_t  regs;
  res_t  res;

  assign advance    = in_valid && (!out_valid || result.ready);
  assign tick.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_data.low_switch    <= tick.low_switch;
      in_data.high_switch   <= tick.high_switch;
      in_data.goal_position <= tick.goal_position;
    end
  end

  shp_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  shp_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .tick (in_data),
    .regs (regs),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  assign result.valid            = out_valid;
  assign result.step_level       = out_data.step_level;
  assign result.direction_level  = out_data.direction_level;
  assign result.motor_status     = out_data.motor_status;
  assign result.current_position = out_data.current_position;
  assign result.travel_span      = out_data.travel_span;

endmodule

// ----- src/shp_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_cfg
// Configuration registers: debounce length and recalibration factor.
// ----------------------------------------------------------------------------
module shp_cfg import shp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  shp_cfg_if.sink cfg,
  output cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ticks <= DEBOUNCE_RESET;
      regs.recal_factor   <= RECAL_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DEBOUNCE_TICKS: regs.debounce_ticks <= cfg.data;
        REG_RECAL_FACTOR:   regs.recal_factor   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/shp_fsm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_fsm
// Homing state machine: one tick per fire, gives the result of that tick.
// ----------------------------------------------------------------------------
module shp_fsm import shp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  tick_t tick,
  input  cfg_t  regs,
  output res_t  res
);

  phase_t             phase, phase_next;
  status_t            status, status_next;
  logic               pulse_high, pulse_high_next;
  logic               dir, dir_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [POS_W-1:0]   span, span_next;
  logic [STEPS_W-1:0] steps, steps_next;
  logic [CFG_W-1:0]   debounce, debounce_next;

  logic [CFG_W-1:0]        debounce_inc;
  logic [STEPS_W-1:0]      steps_inc;
  logic signed [LIM_W-1:0] span_ext, factor_ext, limit;
  logic signed [CMP_W-1:0] pos_cmp, goal_cmp;
  logic                    recal;
  logic                    fault;

  assign debounce_inc = (debounce == '1) ? debounce : debounce + CFG_W'(1);
  assign steps_inc    = (steps == '1) ? steps : steps + STEPS_W'(1);
  assign span_ext     = LIM_W'($signed(span));
  assign factor_ext   = $signed({{(LIM_W-CFG_W){1'b0}}, regs.recal_factor});
  assign limit        = span_ext * factor_ext;
  assign recal        = $signed({1'b0, steps_inc}) > limit;
  assign pos_cmp      = CMP_W'($signed(pos));
  assign goal_cmp     = CMP_W'($signed(tick.goal_position));
  assign fault        = tick.low_switch[1] | tick.high_switch[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FIND;
      status     <= ST_CAL;
      pulse_high <= 1'b0;
      dir        <= 1'b0;
      pos        <= '0;
      span       <= '1;
      steps      <= '0;
      debounce   <= '0;
    end else if (fire) begin
      phase      <= phase_next;
      status     <= status_next;
      pulse_high <= pulse_high_next;
      dir        <= dir_next;
      pos        <= pos_next;
      span       <= span_next;
      steps      <= steps_next;
      debounce   <= debounce_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    status_next     = status;
    pulse_high_next = pulse_high;
    dir_next        = dir;
    pos_next        = pos;
    span_next       = span;
    steps_next      = steps;
    debounce_next   = debounce;
    if (pulse_high) begin
      pulse_high_next = 1'b0;
    end else if (fault) begin
      status_next = ST_ERROR;
    end else begin
      case (phase)
        PH_LEAVE: begin
          if (tick.low_switch == SW_OPEN) begin
            debounce_next = debounce_inc;
            if (debounce_inc >= regs.debounce_ticks) begin
              debounce_next = '0;
              pos_next      = '0;
              phase_next    = PH_MEASURE;
            end
          end else begin
            debounce_next   = '0;
            dir_next        = 1'b1;
            pulse_high_next = 1'b1;
          end
        end
        PH_MEASURE: begin
          if (tick.high_switch == SW_PRESSED) begin
            span_next   = pos;
            steps_next  = '0;
            status_next = ST_CAL;
            phase_next  = PH_LEAVE_TOP;
          end else begin
            dir_next        = 1'b1;
            pulse_high_next = 1'b1;
            pos_next        = pos + POS_W'(1);
          end
        end
        PH_LEAVE_TOP: begin
          if (tick.high_switch == SW_OPEN) begin
            debounce_next = debounce_inc;
            if (debounce_inc >= regs.debounce_ticks) begin
              debounce_next = '0;
              status_next   = ST_RUNNING;
              phase_next    = PH_RUN;
            end
          end else begin
            debounce_next   = '0;
            dir_next        = 1'b0;
            pulse_high_next = 1'b1;
          end
        end
        PH_RUN: begin
          if (pos_cmp == goal_cmp) begin
            status_next = ST_READY;
          end else begin
            status_next = ST_RUNNING;
            if (pos_cmp < goal_cmp && tick.high_switch == SW_PRESSED) begin
              pos_next = span;
            end else if (pos_cmp > goal_cmp && tick.low_switch == SW_PRESSED) begin
              pos_next = '0;
            end else begin
              dir_next        = pos_cmp < goal_cmp;
              pulse_high_next = 1'b1;
              pos_next        = (pos_cmp < goal_cmp) ? pos + POS_W'(1) : pos - POS_W'(1);
              steps_next      = steps_inc;
              if (recal) begin
                steps_next  = '0;
                status_next = ST_CAL;
                phase_next  = PH_FIND;
              end
            end
          end
        end
        default: begin
          phase_next = PH_FIND;
          if (tick.low_switch == SW_PRESSED) begin
            debounce_next = '0;
            phase_next    = PH_LEAVE;
          end else begin
            dir_next        = 1'b0;
            pulse_high_next = 1'b1;
          end
        end
      endcase
    end
  end

  assign res.step_level       = pulse_high_next;
  assign res.direction_level  = dir_next;
  assign res.motor_status     = status_next;
  assign res.current_position = OUT_W'(pos_next);
  assign res.travel_span      = OUT_W'(span_next);

  // a tick with the pulse high only lowers it
  a_pulse_drop: assert property (@(posedge clk) disable iff (rst)
    fire && pulse_high |=> !pulse_high && $stable(pos) && $stable(phase))
    else $error("pulse tick changed more than the step pin");

  // no stepping without a tick
  a_no_idle_step: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(pos) && $stable(pulse_high) && $stable(phase))
    else $error("state moved without a tick");

  // span only written when leaving measurement
  a_span_write: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && span != $past(span) |-> $past(phase) == PH_MEASURE
      && phase == PH_LEAVE_TOP)
    else $error("span written outside measurement");

  // a new step pulse from a low pin in measurement advances the position by one
  a_pulse_rise: assert property (@(posedge clk) disable iff (rst)
    fire && !pulse_high && !fault && (phase == PH_MEASURE) && pulse_high_next
      |=> pos == $past(pos) + POS_W'(1))
    else $error("measurement step without count");

endmodule
